// File: rtl/core/swsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsa_pkg
// Shared widths, limits and state codes for the stratum weighted share
// accumulator.
// ----------------------------------------------------------------------------
package swsa_pkg;

   // field widths
   localparam int EXPR_W   = 32;
   localparam int WEIGHT_W = 6;
   localparam int SLOT_W   = 5;
   localparam int CFG_W    = 6;
   localparam int RESULT_W = 32;
   localparam int FRAC_W   = 24;

   // accumulator widths
   localparam int PROD_W  = EXPR_W + WEIGHT_W;
   localparam int BIN_W   = 58;
   localparam int TOTAL_W = 52;

   // integer bits of the quotient, also the alignment shift of the total
   localparam int SHIFT_W = RESULT_W - FRAC_W;
   localparam int CNT_W   = $clog2(RESULT_W);

   localparam int MAX_STRATA = 32;

   localparam logic [BIN_W-1:0]   BIN_MAX    = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;
   localparam logic [RESULT_W-1:0] RESULT_MAX = '1;

   // sequencer states
   typedef enum logic [5:0] {
      ST_ACCUM = 6'b000001,
      ST_FLUSH = 6'b000010,
      ST_READ  = 6'b000100,
      ST_LOAD  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } swsa_state_type;

endpackage

// File: rtl/core/swsa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsa_div
// Restoring divider, one quotient bit per cycle: floor(bin * 2^24 / total)
// for a bin known to be below total * 2^8, so the quotient fits 32 bits.
// ----------------------------------------------------------------------------
module swsa_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [swsa_pkg::BIN_W-1:0]      bin,
   input  logic [swsa_pkg::TOTAL_W-1:0]    total,
   output logic                            done,
   output logic [swsa_pkg::RESULT_W-1:0]   quotient
);
   import swsa_pkg::*;

   logic [TOTAL_W-1:0]  rem_ff, rem_in;
   logic [RESULT_W-1:0] low_ff, low_in;
   logic [RESULT_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [TOTAL_W:0]    shifted;
   logic [TOTAL_W:0]    diff;
   logic                ge;

   // one trial subtraction of the shifted remainder
   always_comb begin
      shifted = {rem_ff, low_ff[RESULT_W-1]};
      diff    = shifted - {1'b0, total};
      ge      = !diff[TOTAL_W];
   end

   // divider step control
   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // high part of bin * 2^24 already below the total
         rem_in  = TOTAL_W'(bin[BIN_W-1:SHIFT_W]);
         low_in  = {bin[SHIFT_W-1:0], FRAC_W'(0)};
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
         low_in = {low_ff[RESULT_W-2:0], 1'b0};
         quo_in = {quo_ff[RESULT_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RESULT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/stratum_weighted_share_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stratum_weighted_share_accumulator_unit
// Accumulates expression and expression times weight per stratum slot over a
// column; on the last gene emits bin / total in Q8.24 for each stratum in use.
// ----------------------------------------------------------------------------
// Flow: a new gene is taken every cycle while the unit is in its accumulate state.
// The last gene is followed by a flush state, then per result a memory read,
// a load state and the divider run (skipped when the quotient saturates or the
// total is zero) before the result is offered.
// Reset: synchronous, active high; bins, total and valid bits read as zero,
// strata count is 32. No clearing pass: per-slot valid bits clear at once.
// ----------------------------------------------------------------------------
module stratum_weighted_share_accumulator_unit (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            csr_wr_en,
   input  logic [swsa_pkg::CFG_W-1:0]      csr_wr_data,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [swsa_pkg::EXPR_W-1:0]     req_expression_level,
   input  logic [swsa_pkg::WEIGHT_W-1:0]   req_stratum_weight,
   input  logic [swsa_pkg::SLOT_W-1:0]     req_stratum_slot,
   input  logic                            req_last_gene,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [swsa_pkg::SLOT_W-1:0]     rsp_result_slot,
   output logic [swsa_pkg::RESULT_W-1:0]   rsp_partial_index,
   output logic                            rsp_zero_total,
   output logic                            rsp_last_result
);
   import swsa_pkg::*;

   // sequencer and configuration
   swsa_state_type      state_ff, state_in;
   logic [CFG_W-1:0]    strata_ff;
   logic [SLOT_W-1:0]   last_k;
   logic [SLOT_W-1:0]   k_ff, k_in;

   // handshakes
   logic                req_xfer;
   logic                rsp_xfer;

   // column total
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [TOTAL_W:0]    total_sum;

   // bin memory and valid bits
   logic [BIN_W-1:0]    bin_mem [MAX_STRATA];
   logic [BIN_W-1:0]    rd_data_ff;
   logic                mem_rd_en;
   logic [SLOT_W-1:0]   mem_rd_addr;
   logic [MAX_STRATA-1:0] bin_valid_ff, bin_valid_in;

   // update stage
   logic                p1_valid_ff;
   logic [SLOT_W-1:0]   p1_slot_ff;
   logic [PROD_W-1:0]   p1_prod_ff;
   logic                fwd_valid_ff;
   logic [SLOT_W-1:0]   fwd_slot_ff;
   logic [BIN_W-1:0]    fwd_data_ff;
   logic [BIN_W-1:0]    acc_base;
   logic [BIN_W:0]      acc_wide;
   logic [BIN_W-1:0]    acc_sum;

   // result path
   logic [BIN_W-1:0]    ld_bin;
   logic                ld_zero;
   logic                ld_sat;
   logic                div_start;
   logic                div_done;
   logic [RESULT_W-1:0] div_q;
   logic [RESULT_W-1:0] index_ff, index_in;
   logic                zero_ff, zero_in;

   assign req_ready = (state_ff == ST_ACCUM);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_xfer  = rsp_valid && rsp_ready;

   // strata count clamp, as index of the final result
   always_comb begin
      if (strata_ff == '0) begin
         last_k = '0;
      end else if (strata_ff > CFG_W'(MAX_STRATA)) begin
         last_k = SLOT_W'(MAX_STRATA - 1);
      end else begin
         last_k = SLOT_W'(strata_ff - 1'b1);
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         strata_ff <= CFG_W'(MAX_STRATA);
      end else if (csr_wr_en) begin
         strata_ff <= csr_wr_data;
      end
   end

   // saturating column total
   always_comb begin
      total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(req_expression_level);
      total_in  = total_ff;
      if (req_xfer) begin
         total_in = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
      end else if (rsp_xfer && rsp_last_result) begin
         total_in = '0;
      end
   end

   // memory port selection
   assign mem_rd_en   = req_xfer || (state_ff == ST_READ);
   assign mem_rd_addr = (state_ff == ST_ACCUM) ? req_stratum_slot : k_ff;

   // bin memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (p1_valid_ff) begin
         bin_mem[p1_slot_ff] <= acc_sum;
      end
      if (mem_rd_en) begin
         rd_data_ff <= bin_mem[mem_rd_addr];
      end
   end

   // read-modify-write with forwarding of the previous write
   always_comb begin
      if (fwd_valid_ff && (fwd_slot_ff == p1_slot_ff)) begin
         acc_base = fwd_data_ff;
      end else if (bin_valid_ff[p1_slot_ff]) begin
         acc_base = rd_data_ff;
      end else begin
         acc_base = '0;
      end
      acc_wide = {1'b0, acc_base} + (BIN_W + 1)'(p1_prod_ff);
      acc_sum  = acc_wide[BIN_W] ? BIN_MAX : acc_wide[BIN_W-1:0];
   end

   // valid bits: set on write, cleared when the column ends
   always_comb begin
      bin_valid_in = bin_valid_ff;
      if (rsp_xfer && rsp_last_result) begin
         bin_valid_in = '0;
      end else if (p1_valid_ff) begin
         bin_valid_in[p1_slot_ff] = 1'b1;
      end
   end

   // result source for the current slot
   always_comb begin
      ld_bin    = bin_valid_ff[k_ff] ? rd_data_ff : '0;
      ld_zero   = (total_ff == '0);
      ld_sat    = ({2'b0, ld_bin} >= {total_ff, SHIFT_W'(0)});
      div_start = (state_ff == ST_LOAD) && !ld_zero && !ld_sat;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      index_in = index_ff;
      zero_in  = zero_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (req_xfer && req_last_gene) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_READ;
            k_in     = '0;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (ld_zero) begin
               index_in = '0;
               zero_in  = 1'b1;
               state_in = ST_OUT;
            end else if (ld_sat) begin
               index_in = RESULT_MAX;
               zero_in  = 1'b0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               index_in = div_q;
               zero_in  = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_xfer) begin
               if (rsp_last_result) begin
                  state_in = ST_ACCUM;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         k_ff         <= '0;
         total_ff     <= '0;
         bin_valid_ff <= '0;
         p1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         total_ff     <= total_in;
         bin_valid_ff <= bin_valid_in;
         p1_valid_ff  <= req_xfer;
         fwd_valid_ff <= p1_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         p1_slot_ff <= req_stratum_slot;
         p1_prod_ff <= PROD_W'(req_expression_level) * PROD_W'(req_stratum_weight);
      end
      fwd_slot_ff <= p1_slot_ff;
      fwd_data_ff <= acc_sum;
      index_ff    <= index_in;
      zero_ff     <= zero_in;
   end

   // quotient unit
   swsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .bin      (ld_bin),
      .total    (total_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_result_slot   = k_ff;
   assign rsp_partial_index = index_ff;
   assign rsp_zero_total    = zero_ff;
   assign rsp_last_result   = (k_ff == last_k);

endmodule

// File: tb/swsa_share_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsa_share_checker
// Watches the gene, result and register ports of the stratum weighted share
// accumulator. Keeps its own bins and column total, predicts every stratum
// share of a column when the last gene transfers, and compares each result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module swsa_share_checker (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            csr_wr_en,
   input  logic [swsa_pkg::CFG_W-1:0]      csr_wr_data,

   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [swsa_pkg::EXPR_W-1:0]     req_expression_level,
   input  logic [swsa_pkg::WEIGHT_W-1:0]   req_stratum_weight,
   input  logic [swsa_pkg::SLOT_W-1:0]     req_stratum_slot,
   input  logic                            req_last_gene,

   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [swsa_pkg::SLOT_W-1:0]     rsp_result_slot,
   input  logic [swsa_pkg::RESULT_W-1:0]   rsp_partial_index,
   input  logic                            rsp_zero_total,
   input  logic                            rsp_last_result,

   output int                              fail_count,
   output int                              outstanding
);

   import swsa_pkg::*;

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [RESULT_W-1:0] share;
      logic                zero_total;
      logic                last_result;
   } share_result_type;

   logic [BIN_W-1:0]   bin_sum [MAX_STRATA];
   logic [TOTAL_W-1:0] expr_total;
   logic [CFG_W-1:0]   strata_cfg;
   share_result_type   share_queue [$];

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP) begin
         $display("%0d ns swsa check: %s", $time, msg);
      end
      fail_count++;
   endtask

   // floor(bin * 2^24 / total), saturated to the result width
   function automatic logic [RESULT_W-1:0] share_quotient(input logic [BIN_W-1:0]   bin,
                                                          input logic [TOTAL_W-1:0] total);
      logic [BIN_W+FRAC_W-1:0] scaled;
      logic [BIN_W+FRAC_W-1:0] quot;
      scaled = {bin, {FRAC_W{1'b0}}};
      quot   = scaled / total;
      if (quot[BIN_W+FRAC_W-1:RESULT_W] != '0) begin
         return RESULT_MAX;
      end
      return quot[RESULT_W-1:0];
   endfunction

   // fold one gene into the column; on the last gene queue one share per stratum
   task automatic accept_gene(input logic [EXPR_W-1:0]   expr,
                              input logic [WEIGHT_W-1:0] weight,
                              input logic [SLOT_W-1:0]   slot,
                              input logic                last);
      logic [TOTAL_W:0] total_next;
      logic [BIN_W:0]   bin_next;
      int               strata;
      bit               no_expr;
      share_result_type res;
      total_next = {1'b0, expr_total} + expr;
      expr_total = total_next[TOTAL_W] ? TOTAL_MAX : total_next[TOTAL_W-1:0];
      if (int'(slot) < MAX_STRATA) begin
         bin_next = {1'b0, bin_sum[slot]} + expr * weight;
         bin_sum[slot] = bin_next[BIN_W] ? BIN_MAX : bin_next[BIN_W-1:0];
      end
      if (!last) begin
         return;
      end
      // zero strata acts as one, anything above the bin count as the bin count
      strata = (strata_cfg == '0) ? 1 : int'(strata_cfg);
      if (strata > MAX_STRATA) begin
         strata = MAX_STRATA;
      end
      no_expr = (expr_total == '0);
      for (int k = 0; k < strata; k++) begin
         res.slot        = k[SLOT_W-1:0];
         res.share       = no_expr ? '0 : share_quotient(bin_sum[k], expr_total);
         res.zero_total  = no_expr;
         res.last_result = (k == strata - 1);
         share_queue.push_back(res);
      end
      for (int k = 0; k < MAX_STRATA; k++) begin
         bin_sum[k] = '0;
      end
      expr_total = '0;
   endtask

   task automatic check_result();
      share_result_type want;
      if (share_queue.size() == 0) begin
         report_mismatch($sformatf("result for slot %0d with nothing expected",
                                   rsp_result_slot));
         return;
      end
      want = share_queue.pop_front();
      if (rsp_result_slot !== want.slot) begin
         report_mismatch($sformatf("result_slot got %0d expected %0d",
                                   rsp_result_slot, want.slot));
      end
      if (rsp_partial_index !== want.share) begin
         report_mismatch($sformatf("slot %0d partial_index got 0x%08h expected 0x%08h",
                                   want.slot, rsp_partial_index, want.share));
      end
      if (rsp_zero_total !== want.zero_total) begin
         report_mismatch($sformatf("slot %0d zero_total got %b expected %b",
                                   want.slot, rsp_zero_total, want.zero_total));
      end
      if (rsp_last_result !== want.last_result) begin
         report_mismatch($sformatf("slot %0d last_result got %b expected %b",
                                   want.slot, rsp_last_result, want.last_result));
      end
   endtask

   // results are compared before a gene of the same edge is folded in
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_STRATA; k++) begin
            bin_sum[k] = '0;
         end
         expr_total = '0;
         strata_cfg = CFG_W'(MAX_STRATA);
         share_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (csr_wr_en) begin
            strata_cfg = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            accept_gene(req_expression_level, req_stratum_weight, req_stratum_slot,
                        req_last_gene);
         end
      end
      outstanding = share_queue.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives columns of genes and strata count settings into the stratum weighted
// share accumulator: a directed set of edge cases, random columns under
// several strata counts with random gaps on both sides, a long result
// back-pressure stretch, and a closing column of large expressions. The
// checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

   import swsa_pkg::*;

   localparam int CLOCK_LIMIT       = 8_000_000;
   localparam int SETTLE_CYCLES     = 40;
   localparam int HOLD_CYCLES       = 600;
   localparam int TAIL_COLUMN_GENES = 6;
   localparam int PHASE_GENES       = 60;
   localparam int GAP_MAX           = 17;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CFG_W-1:0]      csr_wr_data;
   logic                  req_valid;
   logic                  req_ready;
   logic [EXPR_W-1:0]     req_expression_level;
   logic [WEIGHT_W-1:0]   req_stratum_weight;
   logic [SLOT_W-1:0]     req_stratum_slot;
   logic                  req_last_gene;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [SLOT_W-1:0]     rsp_result_slot;
   logic [RESULT_W-1:0]   rsp_partial_index;
   logic                  rsp_zero_total;
   logic                  rsp_last_result;

   int fail_count;
   int outstanding;
   int cycle_count;
   int req_gap_max   = GAP_MAX;
   int rsp_gap_max   = GAP_MAX;
   int active_strata = MAX_STRATA;
   bit rsp_hold_request = 1'b0;

   stratum_weighted_share_accumulator_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_expression_level (req_expression_level),
      .req_stratum_weight   (req_stratum_weight),
      .req_stratum_slot     (req_stratum_slot),
      .req_last_gene        (req_last_gene),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_slot      (rsp_result_slot),
      .rsp_partial_index    (rsp_partial_index),
      .rsp_zero_total       (rsp_zero_total),
      .rsp_last_result      (rsp_last_result)
   );

   swsa_share_checker i_share_checker (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_expression_level (req_expression_level),
      .req_stratum_weight   (req_stratum_weight),
      .req_stratum_slot     (req_stratum_slot),
      .req_last_gene        (req_last_gene),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_slot      (rsp_result_slot),
      .rsp_partial_index    (rsp_partial_index),
      .rsp_zero_total       (rsp_zero_total),
      .rsp_last_result      (rsp_last_result),
      .fail_count           (fail_count),
      .outstanding          (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop for a hung run
   initial begin : cycle_watchdog
      cycle_count = 0;
      while (cycle_count < CLOCK_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // result side: random ready delay per transfer, one long hold on request
   initial begin : result_sink
      int wait_cycles;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         wait_cycles = $urandom_range(0, rsp_gap_max);
         if (rsp_hold_request) begin
            wait_cycles      = HOLD_CYCLES;
            rsp_hold_request = 1'b0;
         end
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // one gene transfer, preceded by a random gap; returns at the next falling edge
   task automatic send_gene(input logic [EXPR_W-1:0]   expr,
                            input logic [WEIGHT_W-1:0] weight,
                            input logic [SLOT_W-1:0]   slot,
                            input logic                last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_expression_level <= expr;
      req_stratum_weight   <= weight;
      req_stratum_slot     <= slot;
      req_last_gene        <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop sending and wait until every predicted share has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_strata(input int value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[CFG_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      active_strata = (value == 0) ? 1 : ((value > MAX_STRATA) ? MAX_STRATA : value);
   endtask

   // random column: mostly slots in use, some beyond, now and then all-zero
   task automatic send_random_column(input int max_len, output int genes);
      int                len;
      bit                zero_col;
      logic [EXPR_W-1:0] expr;
      logic [SLOT_W-1:0] slot;
      len      = $urandom_range(1, max_len);
      zero_col = ($urandom_range(0, 15) == 0);
      for (int g = 0; g < len; g++) begin
         case ($urandom_range(0, 9))
            0:       expr = '0;
            1:       expr = '1;
            2, 3:    expr = EXPR_W'($urandom_range(0, 255)) << 16;
            4:       expr = EXPR_W'($urandom_range(0, 65535));
            default: expr = $urandom;
         endcase
         if (zero_col) begin
            expr = '0;
         end
         if ($urandom_range(0, 3) != 0) begin
            slot = SLOT_W'($urandom_range(0, active_strata - 1));
         end else begin
            slot = SLOT_W'($urandom_range(0, MAX_STRATA - 1));
         end
         send_gene(expr, WEIGHT_W'($urandom_range(0, 63)), slot, g == len - 1);
      end
      genes = len;
   endtask

   // stimulus and verdict
   initial begin : stimulus
      int strata_plan [8];
      int phase_genes;
      int col_genes;
      int value;

      strata_plan = '{1, 63, 17, 32, 0, 33, -1, -1};

      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_valid            = 1'b0;
      req_expression_level = '0;
      req_stratum_weight   = '0;
      req_stratum_slot     = '0;
      req_last_gene        = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes and alternating bit patterns, reset strata count
      send_gene('1, 6'd63, 5'd0, 1'b0);
      send_gene('0, 6'd0, 5'd31, 1'b0);
      send_gene(32'h0001_0000, 6'd1, 5'd1, 1'b0);
      send_gene(32'hAAAA_AAAA, 6'd42, 5'd21, 1'b0);
      send_gene(32'h5555_5555, 6'd21, 5'd10, 1'b1);
      // zero total, single gene and several genes
      send_gene('0, 6'd63, 5'd31, 1'b1);
      send_gene('0, 6'd5, 5'd3, 1'b0);
      send_gene('0, 6'd9, 5'd4, 1'b0);
      send_gene('0, 6'd0, 5'd0, 1'b1);
      // smallest nonzero expression
      send_gene(32'h0000_0001, 6'd1, 5'd0, 1'b1);

      // one stratum: slots beyond the strata in use fill but are not emitted
      write_strata(1);
      send_gene('1, 6'd63, 5'd31, 1'b0);
      send_gene(32'h0000_1234, 6'd2, 5'd5, 1'b0);
      send_gene(32'h0002_0000, 6'd3, 5'd0, 1'b1);
      // zero strata acts as one
      write_strata(0);
      send_gene(32'h0003_0000, 6'd4, 5'd0, 1'b0);
      send_gene(32'h0000_8000, 6'd60, 5'd2, 1'b1);
      // above the bin count acts as the bin count; high bins must be clear
      write_strata(63);
      send_gene(32'h0001_0000, 6'd1, 5'd0, 1'b1);
      write_strata(33);
      send_gene('1, 6'd62, 5'd30, 1'b1);

      // random columns under several strata counts and idle patterns
      for (int p = 0; p < 8; p++) begin
         value = (strata_plan[p] < 0) ? $urandom_range(0, 63) : strata_plan[p];
         write_strata(value);
         req_gap_max = (p % 3 == 1) ? 0 : GAP_MAX;
         rsp_gap_max = (p % 4 == 2) ? 0 : GAP_MAX;
         // long result stall while short columns keep coming
         if (p == 3) begin
            req_gap_max      = 0;
            rsp_hold_request = 1'b1;
         end
         phase_genes = 0;
         while (phase_genes < PHASE_GENES) begin
            send_random_column((p == 3) ? 3 : 14, col_genes);
            phase_genes += col_genes;
         end
      end

      // closing column: large expressions into bin 0, then slots 1 and 2
      write_strata(3);
      req_gap_max = 0;
      rsp_gap_max = GAP_MAX;
      for (int g = 0; g < TAIL_COLUMN_GENES; g++) begin
         send_gene('1, 6'd63, 5'd0, 1'b0);
      end
      send_gene(32'h0BAD_F00D, 6'd7, 5'd1, 1'b0);
      send_gene(32'h0000_FFFF, 6'd0, 5'd2, 1'b1);

      rsp_gap_max = 0;
      drain_results();
      repeat (200) @(negedge clock);

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
